### sv/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared widths, codes and types of the pedal sensor plausibility check.
// ----------------------------------------------------------------------------
package psp_pkg;

   // Sensor and result widths
   localparam int ADC_BITS   = 10;
   localparam int DIFF_W     = ADC_BITS + 1;
   localparam int PCT_W      = 14;
   localparam int THR_W      = 11;
   localparam int MODE_W     = 2;
   localparam int TLEN_W     = 5;
   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 4;
   localparam int ENTRY_W    = 2 * ADC_BITS;

   localparam int MAX_BREAKPOINTS_DEF = 16;

   localparam logic [PCT_W-1:0]    FULL_SCALE = 14'd10000;
   localparam logic [ADC_BITS-1:0] ADC_MAX    = '1;

   // Shared divider: quotient wide enough for a full-scale position numerator
   localparam int DIV_NUM_W = $clog2(((2 ** ADC_BITS) - 1) * 10000 + 1);
   localparam int DIV_DEN_W = ADC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_CAL_A_MIN  = 3'd0;
   localparam logic [2:0] REG_CAL_A_MAX  = 3'd1;
   localparam logic [2:0] REG_CAL_B_MIN  = 3'd2;
   localparam logic [2:0] REG_CAL_B_MAX  = 3'd3;
   localparam logic [2:0] REG_MODE       = 3'd4;
   localparam logic [2:0] REG_THRESHOLD  = 3'd5;
   localparam logic [2:0] REG_TABLE_LEN  = 3'd6;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PMUL,
      ST_PGO,
      ST_PWAIT,
      ST_RD0,
      ST_RDN,
      ST_CHK,
      ST_SRD,
      ST_SCHK,
      ST_IMUL,
      ST_IGO,
      ST_IWAIT,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

### sv/psp_req_if.sv
// ----------------------------------------------------------------------------
// psp_req_if
// Request channel: one command with sensor readings or a table entry.
// ----------------------------------------------------------------------------
interface psp_req_if;
   logic                             valid;
   logic                             ready;
   logic [psp_pkg::CMD_W-1:0]        cmd;
   logic [psp_pkg::ADC_BITS-1:0]     raw_a;
   logic [psp_pkg::ADC_BITS-1:0]     raw_b;
   logic [psp_pkg::INDEX_W-1:0]      entry_index;
   logic [psp_pkg::ADC_BITS-1:0]     entry_x;
   logic [psp_pkg::ADC_BITS-1:0]     entry_y;

   modport source (output valid, cmd, raw_a, raw_b, entry_index, entry_x, entry_y,
                   input ready);
   modport sink (input valid, cmd, raw_a, raw_b, entry_index, entry_x, entry_y,
                 output ready);
endinterface

### sv/psp_rsp_if.sv
// ----------------------------------------------------------------------------
// psp_rsp_if
// Result channel: pedal position, fault flag and comparison difference.
// ----------------------------------------------------------------------------
interface psp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [psp_pkg::PCT_W-1:0]         pedal_percent;
   logic                              fault;
   logic signed [psp_pkg::DIFF_W-1:0] delta;
   logic                              delta_valid;

   modport source (output valid, pedal_percent, fault, delta, delta_valid,
                   input ready);
   modport sink (input valid, pedal_percent, fault, delta, delta_valid,
                 output ready);
endinterface

### sv/psp_ram.sv
// ----------------------------------------------------------------------------
// psp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/psp_div.sv
// ----------------------------------------------------------------------------
// psp_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  psp_pkg::div_req_type  div_req,
   output psp_pkg::div_rsp_type  div_rsp
);

   localparam int NW = psp_pkg::DIV_NUM_W;
   localparam int DW = psp_pkg::DIV_DEN_W;
   localparam int CW = psp_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          fits;

   always_comb begin
      // The remainder stays below the divisor, so one extra bit holds the shift.
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### sv/pedal_sensor_plausibility.sv
// ----------------------------------------------------------------------------
// pedal_sensor_plausibility
// Redundant pedal sensor scaling and cross-check with a breakpoint table.
// ----------------------------------------------------------------------------
// A request on req_chan is a sample pair, a breakpoint load or a fault clear;
// each request gives exactly one result on rsp_chan. A sample maps the
// preferred sensor's reading to 0..10000 and, with comparison enabled, checks
// the other sensor against the value interpolated from the breakpoint table.
// A mismatch forces the position to 0 and sets a sticky fault.
// Requests are handled one at a time; load and clear requests skip the
// divider. A sample without comparison is paced by the shared divider; with
// comparison its time grows with the number of breakpoints, since the
// table is scanned through one RAM read port and the interpolation divide
// runs on the same divider.
// The result sits in an output register, so the next request is taken while
// a result waits for rsp_chan.ready; a stalled receiver holds the block only
// when the following result is ready too.
// Reset clears the fault flag and loads the register defaults; the breakpoint
// RAM holds nothing defined until entries are loaded. Configuration is written
// over the csr_ port by the user only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module pedal_sensor_plausibility #(
   parameter int MAX_BREAKPOINTS = psp_pkg::MAX_BREAKPOINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   psp_req_if.sink                     req_chan,
   psp_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [psp_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [psp_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [psp_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int IDX_W = $clog2(MAX_BREAKPOINTS);
   localparam int AW    = psp_pkg::ADC_BITS;
   localparam int SW    = psp_pkg::DIFF_W;
   localparam int EW    = psp_pkg::ENTRY_W;
   localparam int NW    = psp_pkg::DIV_NUM_W;
   localparam int PW    = psp_pkg::PCT_W;
   localparam int TW    = psp_pkg::THR_W;
   localparam int YW    = psp_pkg::DIV_NUM_W + 2;
   localparam int DWD   = psp_pkg::CSR_DW;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [AW-1:0]                 cal_a_min_ff, cal_a_min_in;
   logic [AW-1:0]                 cal_a_max_ff, cal_a_max_in;
   logic [AW-1:0]                 cal_b_min_ff, cal_b_min_in;
   logic [AW-1:0]                 cal_b_max_ff, cal_b_max_in;
   logic [psp_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [TW-1:0]                 thr_ff, thr_in;
   logic [psp_pkg::TLEN_W-1:0]    tlen_ff, tlen_in;
   logic                          csr_wr;
   logic [2:0]                    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[psp_pkg::CSR_AW-1:2];

   always_comb begin
      cal_a_min_in = cal_a_min_ff;
      cal_a_max_in = cal_a_max_ff;
      cal_b_min_in = cal_b_min_ff;
      cal_b_max_in = cal_b_max_ff;
      mode_in      = mode_ff;
      thr_in       = thr_ff;
      tlen_in      = tlen_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            psp_pkg::REG_CAL_A_MIN: cal_a_min_in = csr_pwdata[AW-1:0];
            psp_pkg::REG_CAL_A_MAX: cal_a_max_in = csr_pwdata[AW-1:0];
            psp_pkg::REG_CAL_B_MIN: cal_b_min_in = csr_pwdata[AW-1:0];
            psp_pkg::REG_CAL_B_MAX: cal_b_max_in = csr_pwdata[AW-1:0];
            psp_pkg::REG_MODE:      mode_in      = csr_pwdata[psp_pkg::MODE_W-1:0];
            psp_pkg::REG_THRESHOLD: thr_in       = csr_pwdata[TW-1:0];
            psp_pkg::REG_TABLE_LEN: tlen_in      = csr_pwdata[psp_pkg::TLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         psp_pkg::REG_CAL_A_MIN: csr_prdata = DWD'(cal_a_min_ff);
         psp_pkg::REG_CAL_A_MAX: csr_prdata = DWD'(cal_a_max_ff);
         psp_pkg::REG_CAL_B_MIN: csr_prdata = DWD'(cal_b_min_ff);
         psp_pkg::REG_CAL_B_MAX: csr_prdata = DWD'(cal_b_max_ff);
         psp_pkg::REG_MODE:      csr_prdata = DWD'(mode_ff);
         psp_pkg::REG_THRESHOLD: csr_prdata = DWD'(thr_ff);
         psp_pkg::REG_TABLE_LEN: csr_prdata = DWD'(tlen_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and sequencer
   // ------------------------------------------------------------------
   psp_pkg::state_type            state_ff, state_in;
   logic [psp_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [AW-1:0]                 raw_a_ff, raw_a_in;
   logic [AW-1:0]                 raw_b_ff, raw_b_in;
   logic [NW-1:0]                 dividend_ff, dividend_in;
   logic [AW-1:0]                 divisor_ff, divisor_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   logic [PW-1:0]                 pct_ff, pct_in;
   logic [AW-1:0]                 prev_x_ff, prev_x_in;
   logic [AW-1:0]                 prev_y_ff, prev_y_in;
   logic [AW-1:0]                 seg_y1_ff, seg_y1_in;
   logic [AW-1:0]                 ylast_ff, ylast_in;
   logic [AW-1:0]                 yexp_ff, yexp_in;
   logic [IDX_W-1:0]              j_ff, j_in;
   logic signed [SW-1:0]          delta_ff, delta_in;
   logic                          mism_ff, mism_in;
   logic                          dv_ff, dv_in;
   logic                          fault_ff, fault_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                 rsp_pct_ff, rsp_pct_in;
   logic                          rsp_fault_ff, rsp_fault_in;
   logic signed [SW-1:0]          rsp_delta_ff, rsp_delta_in;
   logic                          rsp_dv_ff, rsp_dv_in;

   logic                          req_fire;
   logic                          rsp_free;
   logic                          prefer_a;
   logic                          compare_en;
   logic [AW-1:0]                 pref_raw, other_raw;
   logic [AW-1:0]                 cal_lo, cal_hi;
   logic [IDX_W-1:0]              last_idx;

   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [EW-1:0]                 ram_wdata;
   logic [IDX_W-1:0]              ram_raddr;
   logic [EW-1:0]                 ram_rdata;
   logic [AW-1:0]                 rd_x, rd_y;

   psp_pkg::div_req_type          div_req;
   psp_pkg::div_rsp_type          div_rsp;

   logic signed [SW-1:0]          num_s, span_s, a_s, b_s, dx_s, d_s;
   logic [AW-1:0]                 num_mag, span_mag, a_mag, b_mag, d_mag;
   logic signed [YW-1:0]          q_s, y_s;

   assign prefer_a   = mode_ff[0];
   assign compare_en = mode_ff[1];
   assign pref_raw   = prefer_a ? raw_a_ff : raw_b_ff;
   assign other_raw  = prefer_a ? raw_b_ff : raw_a_ff;
   assign cal_lo     = prefer_a ? cal_a_min_ff : cal_b_min_ff;
   assign cal_hi     = prefer_a ? cal_a_max_ff : cal_b_max_ff;
   assign rd_x       = ram_rdata[EW-1:AW];
   assign rd_y       = ram_rdata[AW-1:0];

   assign req_chan.ready = (state_ff == psp_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Table length saturates to between 2 entries and the depth of the RAM.
   always_comb begin
      if (tlen_ff < psp_pkg::TLEN_W'(2)) begin
         last_idx = IDX_W'(1);
      end else if (32'(tlen_ff) > 32'(MAX_BREAKPOINTS)) begin
         last_idx = IDX_W'(MAX_BREAKPOINTS - 1);
      end else begin
         last_idx = IDX_W'(32'(tlen_ff) - 32'd1);
      end
   end

   assign ram_we    = req_fire && (req_chan.cmd == psp_pkg::CMD_LOAD) &&
                      (32'(req_chan.entry_index) < 32'(MAX_BREAKPOINTS));
   assign ram_waddr = IDX_W'(req_chan.entry_index);
   assign ram_wdata = {req_chan.entry_x, req_chan.entry_y};

   always_comb begin
      unique case (state_ff)
         psp_pkg::ST_RD0: ram_raddr = '0;
         psp_pkg::ST_RDN: ram_raddr = last_idx;
         psp_pkg::ST_SRD: ram_raddr = j_ff;
         default:         ram_raddr = '0;
      endcase
   end

   psp_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_BREAKPOINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign div_req.start    = (state_ff == psp_pkg::ST_PGO) ||
                             (state_ff == psp_pkg::ST_IGO);
   assign div_req.dividend = dividend_ff;
   assign div_req.divisor  = divisor_ff;

   psp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      // Signed differences and magnitudes for both divides and the comparison.
      num_s    = $signed({1'b0, pref_raw}) - $signed({1'b0, cal_lo});
      span_s   = $signed({1'b0, cal_hi}) - $signed({1'b0, cal_lo});
      num_mag  = num_s[SW-1] ? AW'(-num_s) : num_s[AW-1:0];
      span_mag = span_s[SW-1] ? AW'(-span_s) : span_s[AW-1:0];
      a_s      = $signed({1'b0, pref_raw}) - $signed({1'b0, prev_x_ff});
      b_s      = $signed({1'b0, seg_y1_ff}) - $signed({1'b0, prev_y_ff});
      a_mag    = a_s[SW-1] ? AW'(-a_s) : a_s[AW-1:0];
      b_mag    = b_s[SW-1] ? AW'(-b_s) : b_s[AW-1:0];
      dx_s     = $signed({1'b0, rd_x}) - $signed({1'b0, prev_x_ff});
      d_s      = $signed({1'b0, other_raw}) - $signed({1'b0, yexp_ff});
      d_mag    = d_s[SW-1] ? AW'(-d_s) : d_s[AW-1:0];
      q_s      = $signed({2'b00, div_rsp.quotient});
      y_s      = $signed(YW'(prev_y_ff)) + (neg_ff ? -q_s : q_s);

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      raw_a_in     = raw_a_ff;
      raw_b_in     = raw_b_ff;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      pct_in       = pct_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      seg_y1_in    = seg_y1_ff;
      ylast_in     = ylast_ff;
      yexp_in      = yexp_ff;
      j_in         = j_ff;
      delta_in     = delta_ff;
      mism_in      = mism_ff;
      dv_in        = dv_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_pct_in   = rsp_pct_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_dv_in    = rsp_dv_ff;

      unique case (state_ff)
         psp_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_chan.cmd;
               raw_a_in = req_chan.raw_a;
               raw_b_in = req_chan.raw_b;
               pct_in   = '0;
               delta_in = '0;
               mism_in  = 1'b0;
               dv_in    = 1'b0;
               state_in = (req_chan.cmd == psp_pkg::CMD_SAMPLE) ?
                          psp_pkg::ST_PMUL : psp_pkg::ST_DONE;
            end
         end
         psp_pkg::ST_PMUL: begin
            dividend_in = NW'(num_mag) * NW'(psp_pkg::FULL_SCALE);
            divisor_in  = span_mag;
            neg_in      = num_s[SW-1] ^ span_s[SW-1];
            zero_in     = (span_mag == '0);
            state_in    = psp_pkg::ST_PGO;
         end
         psp_pkg::ST_PGO: begin
            state_in = psp_pkg::ST_PWAIT;
         end
         psp_pkg::ST_PWAIT: begin
            if (div_rsp.done) begin
               // A negative quotient clamps to zero, as does an empty span.
               if (zero_ff || neg_ff) begin
                  pct_in = '0;
               end else if (div_rsp.quotient > NW'(psp_pkg::FULL_SCALE)) begin
                  pct_in = psp_pkg::FULL_SCALE;
               end else begin
                  pct_in = div_rsp.quotient[PW-1:0];
               end
               state_in = compare_en ? psp_pkg::ST_RD0 : psp_pkg::ST_DONE;
            end
         end
         psp_pkg::ST_RD0: begin
            state_in = psp_pkg::ST_RDN;
         end
         psp_pkg::ST_RDN: begin
            prev_x_in = rd_x;
            prev_y_in = rd_y;
            state_in  = psp_pkg::ST_CHK;
         end
         psp_pkg::ST_CHK: begin
            // The read data now holds the last breakpoint in use.
            if (pref_raw <= prev_x_ff) begin
               yexp_in  = prev_y_ff;
               state_in = psp_pkg::ST_CMP;
            end else if (pref_raw >= rd_x) begin
               yexp_in  = rd_y;
               state_in = psp_pkg::ST_CMP;
            end else begin
               ylast_in = rd_y;
               j_in     = IDX_W'(1);
               state_in = psp_pkg::ST_SRD;
            end
         end
         psp_pkg::ST_SRD: begin
            state_in = psp_pkg::ST_SCHK;
         end
         psp_pkg::ST_SCHK: begin
            if (pref_raw < rd_x) begin
               if (dx_s[SW-1] || (dx_s == '0)) begin
                  yexp_in  = prev_y_ff;
                  state_in = psp_pkg::ST_CMP;
               end else begin
                  divisor_in = dx_s[AW-1:0];
                  seg_y1_in  = rd_y;
                  state_in   = psp_pkg::ST_IMUL;
               end
            end else if (j_ff == last_idx) begin
               yexp_in  = ylast_ff;
               state_in = psp_pkg::ST_CMP;
            end else begin
               prev_x_in = rd_x;
               prev_y_in = rd_y;
               j_in      = j_ff + IDX_W'(1);
               state_in  = psp_pkg::ST_SRD;
            end
         end
         psp_pkg::ST_IMUL: begin
            dividend_in = NW'(a_mag) * NW'(b_mag);
            neg_in      = a_s[SW-1] ^ b_s[SW-1];
            state_in    = psp_pkg::ST_IGO;
         end
         psp_pkg::ST_IGO: begin
            state_in = psp_pkg::ST_IWAIT;
         end
         psp_pkg::ST_IWAIT: begin
            if (div_rsp.done) begin
               if (y_s[YW-1]) begin
                  yexp_in = '0;
               end else if (y_s > $signed(YW'(psp_pkg::ADC_MAX))) begin
                  yexp_in = psp_pkg::ADC_MAX;
               end else begin
                  yexp_in = y_s[AW-1:0];
               end
               state_in = psp_pkg::ST_CMP;
            end
         end
         psp_pkg::ST_CMP: begin
            delta_in = d_s;
            dv_in    = 1'b1;
            mism_in  = (TW'(d_mag) >= thr_ff);
            state_in = psp_pkg::ST_DONE;
         end
         psp_pkg::ST_DONE: begin
            if (rsp_free) begin
               if (cmd_ff == psp_pkg::CMD_CLEAR) begin
                  fault_in = 1'b0;
               end else if (mism_ff) begin
                  fault_in = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_pct_in   = mism_ff ? '0 : pct_ff;
               rsp_fault_in = fault_in;
               rsp_delta_in = delta_ff;
               rsp_dv_in    = dv_ff;
               state_in     = psp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psp_pkg::ST_IDLE;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cal_a_min_ff <= '0;
         cal_a_max_ff <= '1;
         cal_b_min_ff <= '0;
         cal_b_max_ff <= '1;
         mode_ff      <= psp_pkg::MODE_W'(1);
         thr_ff       <= TW'(50);
         tlen_ff      <= psp_pkg::TLEN_W'(2);
      end else begin
         state_ff     <= state_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         cal_a_min_ff <= cal_a_min_in;
         cal_a_max_ff <= cal_a_max_in;
         cal_b_min_ff <= cal_b_min_in;
         cal_b_max_ff <= cal_b_max_in;
         mode_ff      <= mode_in;
         thr_ff       <= thr_in;
         tlen_ff      <= tlen_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      raw_a_ff     <= raw_a_in;
      raw_b_ff     <= raw_b_in;
      dividend_ff  <= dividend_in;
      divisor_ff   <= divisor_in;
      neg_ff       <= neg_in;
      zero_ff      <= zero_in;
      pct_ff       <= pct_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      seg_y1_ff    <= seg_y1_in;
      ylast_ff     <= ylast_in;
      yexp_ff      <= yexp_in;
      j_ff         <= j_in;
      delta_ff     <= delta_in;
      mism_ff      <= mism_in;
      dv_ff        <= dv_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_dv_ff    <= rsp_dv_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pedal_percent = rsp_pct_ff;
   assign rsp_chan.fault         = rsp_fault_ff;
   assign rsp_chan.delta         = rsp_delta_ff;
   assign rsp_chan.delta_valid   = rsp_dv_ff;

endmodule
